FILE: hdl/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation core.
// No dependencies; every other file in hdl/ but bsc_delay.sv refers to this package by scope.
`default_nettype none

package bsc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TEMP_COEF = 3'd0,
        REG_P_OFFSET  = 3'd1,
        REG_P_LINEAR  = 3'd2,
        REG_T_CROSS   = 3'd3,
        REG_MIXED     = 3'd4,
        REG_SECOND    = 3'd5,
        REG_CUBIC     = 3'd6,
        REG_OSR       = 3'd7
    } cfg_reg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [5:0] OSR_RESET = 6'd28;

    // Calibration set as seen by the datapath
    typedef struct packed {
        logic [11:0] c0;
        logic [11:0] c1;
        logic [19:0] c00;
        logic [19:0] c10;
        logic [15:0] c01;
        logic [15:0] c11;
        logic [15:0] c20;
        logic [15:0] c21;
        logic [15:0] c30;
        logic [2:0]  tcode;
        logic [2:0]  pcode;
    } coef_t;

    // Scale factor per oversampling code is OSR_DIV * 2^OSR_SHIFT
    localparam logic [7:0] OSR_DIV [8] = '{
        8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
    };
    localparam logic [4:0] OSR_SHIFT [8] = '{
        5'd19, 5'd19, 5'd19, 5'd19, 5'd13, 5'd13, 5'd13, 5'd13
    };

    // Quotient bits resolved per divider stage
    localparam int DIV_BPS = 4;
    // Multiplier slice width
    localparam int MUL_CHUNK = 32;
    // Fixed-point multiply latency
    localparam int FMUL_LAT = 5;
    // Polynomial pipeline depth, divider output to result register
    localparam int POLY_STAGES = 17;

    // Output field limits
    localparam int TEMP_MAX = 65535;
    localparam int TEMP_MIN = -65536;
    localparam int PRES_MAX = 8388607;
    localparam int PRES_MIN = -8388608;

    // Intermediate values are held within +-(2^63-1)
    localparam logic signed [63:0] LIM64  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] NLIM64 = 64'sh8000_0000_0000_0001;

    // Saturating add in the 64-bit domain
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(LIM64))
            return LIM64;
        else if (s < 65'(NLIM64))
            return NLIM64;
        else
            return s[63:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bsc_delay.sv
// Enabled shift-register delay line for payload alignment.
// Standalone; no package use.
`default_nettype none

module bsc_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    // shift on pipeline advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++)
                sr_reg[i] <= sr_reg[i-1];
        end
    end

    assign q = sr_reg[N-1];

endmodule

`default_nettype wire

FILE: hdl/bsc_scale_div.sv
// Reading scaler: pipelined long division of both raw readings by the
// oversampling scale factor. Uses bsc_pkg tables.
`default_nettype none

module bsc_scale_div #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic signed [23:0]          raw_temp,
    input  wire logic signed [23:0]          raw_pressure,
    input  wire logic [2:0]                  tcode,
    input  wire logic [2:0]                  pcode,
    output logic                             out_vld,
    output logic signed [FRAC_BITS+6:0]      t_val,
    output logic signed [FRAC_BITS+6:0]      p_val
);

    localparam int XW   = FRAC_BITS + 7;
    localparam int DW   = FRAC_BITS + 11;
    localparam int EW   = 24 + FRAC_BITS;
    localparam int BPS  = bsc_pkg::DIV_BPS;
    localparam int NSTG = (DW + BPS - 1) / BPS;
    localparam int PDW  = NSTG * BPS;
    localparam int SW   = 8 + 2 * PDW;

    // lane 0 is temperature, lane 1 is pressure
    logic [PDW-1:0]  dvd_reg [NSTG+1][2];
    logic [PDW-1:0]  quo_reg [NSTG+1][2];
    logic [7:0]      rem_reg [NSTG+1][2];
    logic            sgn_reg [NSTG+1][2];
    logic [NSTG:0]   vld_reg;
    logic            out_vld_reg;
    logic signed [XW-1:0] t_val_reg;
    logic signed [XW-1:0] p_val_reg;
    logic [7:0]      div_t;
    logic [7:0]      div_p;

    assign div_t = bsc_pkg::OSR_DIV[tcode];
    assign div_p = bsc_pkg::OSR_DIV[pcode];

    // |raw| * 2^FRAC_BITS, then the power-of-two part of the scale
    function automatic logic [PDW-1:0] prep_dvd(input logic [23:0] raw,
                                                input logic [2:0]  code);
        logic [23:0]   m;
        logic [EW-1:0] ext;
        m   = raw[23] ? (~raw + 24'd1) : raw;
        ext = {m, {FRAC_BITS{1'b0}}};
        ext = ext >> bsc_pkg::OSR_SHIFT[code];
        return PDW'(ext[DW-1:0]);
    endfunction

    // BPS restoring division steps
    function automatic logic [SW-1:0] div_step(input logic [7:0]     r_in,
                                               input logic [PDW-1:0] dv_in,
                                               input logic [PDW-1:0] q_in,
                                               input logic [7:0]     d);
        logic [8:0]     r9;
        logic [7:0]     r;
        logic [PDW-1:0] dv;
        logic [PDW-1:0] q;
        r  = r_in;
        dv = dv_in;
        q  = q_in;
        for (int k = 0; k < BPS; k++)
        begin
            r9 = {r, dv[PDW-1]};
            dv = dv << 1;
            if (r9 >= {1'b0, d})
            begin
                r = 8'(r9 - {1'b0, d});
                q = {q[PDW-2:0], 1'b1};
            end
            else
            begin
                r = r9[7:0];
                q = {q[PDW-2:0], 1'b0};
            end
        end
        return {r, dv, q};
    endfunction

    // prep stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg[0][0] <= prep_dvd(raw_temp, tcode);
            dvd_reg[0][1] <= prep_dvd(raw_pressure, pcode);
            quo_reg[0][0] <= '0;
            quo_reg[0][1] <= '0;
            rem_reg[0][0] <= '0;
            rem_reg[0][1] <= '0;
            sgn_reg[0][0] <= raw_temp[23];
            sgn_reg[0][1] <= raw_pressure[23];
        end
    end

    // division stages
    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        logic [SW-1:0] nxt_t;
        logic [SW-1:0] nxt_p;

        always_comb
        begin
            nxt_t = div_step(rem_reg[g][0], dvd_reg[g][0], quo_reg[g][0], div_t);
            nxt_p = div_step(rem_reg[g][1], dvd_reg[g][1], quo_reg[g][1], div_p);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {rem_reg[g+1][0], dvd_reg[g+1][0], quo_reg[g+1][0]} <= nxt_t;
                {rem_reg[g+1][1], dvd_reg[g+1][1], quo_reg[g+1][1]} <= nxt_p;
                sgn_reg[g+1][0] <= sgn_reg[g][0];
                sgn_reg[g+1][1] <= sgn_reg[g][1];
            end
        end
    end

    // restore sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_val_reg <= sgn_reg[NSTG][0] ? -$signed({1'b0, quo_reg[NSTG][0][XW-2:0]})
                                          :  $signed({1'b0, quo_reg[NSTG][0][XW-2:0]});
            p_val_reg <= sgn_reg[NSTG][1] ? -$signed({1'b0, quo_reg[NSTG][1][XW-2:0]})
                                          :  $signed({1'b0, quo_reg[NSTG][1][XW-2:0]});
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NSTG-1:0], in_vld};
            out_vld_reg <= vld_reg[NSTG];
        end
    end

    assign out_vld = out_vld_reg;
    assign t_val   = t_val_reg;
    assign p_val   = p_val_reg;

endmodule

`default_nettype wire

FILE: hdl/bsc_fmul.sv
// Fixed-point multiply: sign-magnitude product of two values, shifted right
// by FRAC_BITS and clamped to +-(2^63-1). Five stages. Uses bsc_pkg.
`default_nettype none

module bsc_fmul #(
    parameter int FRAC_BITS = 24,
    parameter int XW        = 31
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [XW-1:0] x,
    input  wire logic signed [63:0]   y,
    output logic signed [63:0]        z
);

    localparam int CH  = bsc_pkg::MUL_CHUNK;
    localparam int BW  = 63;
    localparam int NA  = (XW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int PAW = NA * CH;
    localparam int PBW = NB * CH;
    localparam int PW  = PAW + PBW;
    localparam int RW  = CH + PBW;

    logic [XW-1:0]   ux;
    logic [63:0]     uy;
    logic [PAW-1:0]  ua_reg;
    logic [PBW-1:0]  ub_reg;
    logic [3:0]      neg_reg;
    logic [2*CH-1:0] pp_reg [NA][NB];
    logic [RW-1:0]   row_sum [NA];
    logic [RW-1:0]   row_reg [NA];
    logic [PW-1:0]   prod_sum;
    logic [PW-1:0]   prod_reg;
    logic [PW-1:0]   sh;
    logic [62:0]     mag;
    logic signed [63:0] z_reg;

    // magnitudes
    assign ux = x[XW-1] ? (~x + 1'b1) : x;
    assign uy = y[63] ? (~y + 64'd1) : y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg  <= PAW'(ux);
            ub_reg  <= PBW'(uy[62:0]);
            neg_reg <= {neg_reg[2:0], x[XW-1] ^ y[63]};
        end
    end

    // partial products, one slice pair each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
                for (int j = 0; j < NB; j++)
                    pp_reg[i][j] <= (2*CH)'(ua_reg[i*CH +: CH]) *
                                    (2*CH)'(ub_reg[j*CH +: CH]);
        end
    end

    // row sums
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_sum[i] = '0;
            for (int j = 0; j < NB; j++)
                row_sum[i] = row_sum[i] + (RW'(pp_reg[i][j]) << (CH*j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            row_reg <= row_sum;
    end

    // final sum
    always_comb
    begin
        prod_sum = '0;
        for (int i = 0; i < NA; i++)
            prod_sum = prod_sum + (PW'(row_reg[i]) << (CH*i));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_sum;
    end

    // rescale, clamp, sign
    assign sh  = prod_reg >> FRAC_BITS;
    assign mag = (|sh[PW-1:63]) ? {63{1'b1}} : sh[62:0];

    always_ff @(posedge clk)
    begin
        if (en)
            z_reg <= neg_reg[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign z = z_reg;

endmodule

`default_nettype wire

FILE: hdl/bsc_poly.sv
// Calibration polynomials for temperature and pressure, 17 stages.
// Uses bsc_pkg, bsc_fmul and bsc_delay.
`default_nettype none

module bsc_poly #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic signed [FRAC_BITS+6:0] t_val,
    input  wire logic signed [FRAC_BITS+6:0] p_val,
    input  wire bsc_pkg::coef_t              coef,
    output logic                             out_vld,
    output logic signed [16:0]               temperature,
    output logic signed [23:0]               pressure_pa
);

    localparam int XW  = FRAC_BITS + 7;
    localparam int TVW = FRAC_BITS + 20;
    localparam int QTW = TVW - FRAC_BITS;
    localparam int QPW = 64 - FRAC_BITS;
    localparam int NS  = bsc_pkg::POLY_STAGES;
    localparam int FL  = bsc_pkg::FMUL_LAT;

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;
    logic signed [63:0] c00s, c10s, c11s, c20s;

    logic signed [16+XW-1:0] m30_reg, m21_reg, m01_reg;
    logic signed [12+XW-1:0] m1t_reg;
    logic signed [63:0]      a0_reg, b0_reg;
    logic signed [TVW-1:0]   tv_reg;
    logic signed [16:0]      tr_reg;
    logic signed [QTW-1:0]   tq;
    logic signed [16:0]      tr_next;
    logic signed [XW-1:0]    p2, t2, p8, t8;
    logic signed [63:0]      fm1, fm2, fm3, fm4;
    logic signed [63:0]      a1_reg, b1_reg, a2_reg, b14_reg, s1_reg, b15_reg, s_reg;
    logic [16+XW-1:0]        m01_d;
    logic [16:0]             tr_d;
    logic signed [QPW-1:0]   pq;
    logic signed [23:0]      pr_next;
    logic [NS-1:0]           vld_reg;
    logic signed [16:0]      temperature_reg;
    logic signed [23:0]      pressure_reg;

    assign c0  = coef.c0;
    assign c1  = coef.c1;
    assign c00 = coef.c00;
    assign c10 = coef.c10;
    assign c01 = coef.c01;
    assign c11 = coef.c11;
    assign c20 = coef.c20;
    assign c21 = coef.c21;
    assign c30 = coef.c30;

    // coefficients lifted to fixed point
    assign c00s = 64'(c00) <<< FRAC_BITS;
    assign c10s = 64'(c10) <<< FRAC_BITS;
    assign c11s = 64'(c11) <<< FRAC_BITS;
    assign c20s = 64'(c20) <<< FRAC_BITS;

    // stage 1: coefficient products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m30_reg <= c30 * p_val;
            m21_reg <= c21 * p_val;
            m01_reg <= c01 * t_val;
            m1t_reg <= c1 * t_val;
        end
    end

    // stage 2: inner terms and temperature sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= bsc_pkg::sat_add(64'(m30_reg), c20s);
            b0_reg <= bsc_pkg::sat_add(c11s, 64'(m21_reg));
            tv_reg <= (TVW'(c0) <<< (FRAC_BITS-1)) + TVW'(m1t_reg);
        end
    end

    // stage 3: temperature truncated toward zero and clamped
    always_comb
    begin
        tq = tv_reg[TVW-1:FRAC_BITS] + QTW'(tv_reg[TVW-1] && (|tv_reg[FRAC_BITS-1:0]));
        if (tq > bsc_pkg::TEMP_MAX)
            tr_next = 17'(bsc_pkg::TEMP_MAX);
        else if (tq < bsc_pkg::TEMP_MIN)
            tr_next = 17'(bsc_pkg::TEMP_MIN);
        else
            tr_next = tq[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tr_reg <= tr_next;
    end

    // operand alignment
    bsc_delay #(.W(XW), .N(2)) u_p2 (.clk(clk), .en(en), .d(p_val), .q(p2));
    bsc_delay #(.W(XW), .N(2)) u_t2 (.clk(clk), .en(en), .d(t_val), .q(t2));
    bsc_delay #(.W(XW), .N(FL+1)) u_p8 (.clk(clk), .en(en), .d(p2), .q(p8));
    bsc_delay #(.W(XW), .N(FL+1)) u_t8 (.clk(clk), .en(en), .d(t2), .q(t8));
    bsc_delay #(.W(16+XW), .N(13)) u_m01 (.clk(clk), .en(en), .d(m01_reg), .q(m01_d));
    bsc_delay #(.W(17), .N(13)) u_tr (.clk(clk), .en(en), .d(tr_reg), .q(tr_d));

    // stages 3-7: p*(c20 + p*c30) and p*(c11 + p*c21)
    bsc_fmul #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_fm1
        (.clk(clk), .en(en), .x(p2), .y(a0_reg), .z(fm1));
    bsc_fmul #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_fm2
        (.clk(clk), .en(en), .x(p2), .y(b0_reg), .z(fm2));

    // stage 8
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= bsc_pkg::sat_add(c10s, fm1);
            b1_reg <= fm2;
        end
    end

    // stages 9-13: second products
    bsc_fmul #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_fm3
        (.clk(clk), .en(en), .x(p8), .y(a1_reg), .z(fm3));
    bsc_fmul #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_fm4
        (.clk(clk), .en(en), .x(t8), .y(b1_reg), .z(fm4));

    // stages 14-16: final sums, in model order
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg  <= bsc_pkg::sat_add(c00s, fm3);
            b14_reg <= fm4;
            s1_reg  <= bsc_pkg::sat_add(a2_reg, 64'($signed(m01_d)));
            b15_reg <= b14_reg;
            s_reg   <= bsc_pkg::sat_add(s1_reg, b15_reg);
        end
    end

    // stage 17: pressure truncated toward zero and clamped
    always_comb
    begin
        pq = s_reg[63:FRAC_BITS] + QPW'(s_reg[63] && (|s_reg[FRAC_BITS-1:0]));
        if (pq > bsc_pkg::PRES_MAX)
            pr_next = 24'(bsc_pkg::PRES_MAX);
        else if (pq < bsc_pkg::PRES_MIN)
            pr_next = 24'(bsc_pkg::PRES_MIN);
        else
            pr_next = pq[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temperature_reg <= tr_d;
            pressure_reg    <= pr_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], in_vld};
    end

    assign out_vld     = vld_reg[NS-1];
    assign temperature = temperature_reg;
    assign pressure_pa = pressure_reg;

endmodule

`default_nettype wire

FILE: hdl/baro_sensor_compensation_core.sv
// Throughput: one word per cycle unless stalled; the scaler resolves 4 quotient bits per stage
// and the pressure path runs two dependent pairs of five-stage fixed-point multipliers.
// The whole pipeline holds only while a finished result is stalled at the output.
// Reset clears all valid bits and loads configuration registers with their defaults.
// Top level: config registers, bsc_scale_div, bsc_poly; uses bsc_pkg.
`default_nettype none

module baro_sensor_compensation_core #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [23:0]                  raw_temp,
    input  wire logic signed [23:0]                  raw_pressure,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [16:0]                       temperature,
    output logic signed [23:0]                       pressure_pa
);

    localparam int XW = FRAC_BITS + 7;

    logic [23:0] temp_coef_reg;
    logic [19:0] p_offset_reg;
    logic [19:0] p_linear_reg;
    logic [15:0] t_cross_reg;
    logic [15:0] mixed_reg;
    logic [31:0] second_reg;
    logic [15:0] cubic_reg;
    logic [5:0]  osr_reg;
    bsc_pkg::coef_t coef;
    logic        en;
    logic        div_vld;
    logic signed [XW-1:0] t_val;
    logic signed [XW-1:0] p_val;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coef_reg <= '0;
            p_offset_reg  <= '0;
            p_linear_reg  <= '0;
            t_cross_reg   <= '0;
            mixed_reg     <= '0;
            second_reg    <= '0;
            cubic_reg     <= '0;
            osr_reg       <= bsc_pkg::OSR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bsc_pkg::cfg_reg_t'(cfg_index))
                bsc_pkg::REG_TEMP_COEF: temp_coef_reg <= cfg_data[23:0];
                bsc_pkg::REG_P_OFFSET:  p_offset_reg  <= cfg_data[19:0];
                bsc_pkg::REG_P_LINEAR:  p_linear_reg  <= cfg_data[19:0];
                bsc_pkg::REG_T_CROSS:   t_cross_reg   <= cfg_data[15:0];
                bsc_pkg::REG_MIXED:     mixed_reg     <= cfg_data[15:0];
                bsc_pkg::REG_SECOND:    second_reg    <= cfg_data[31:0];
                bsc_pkg::REG_CUBIC:     cubic_reg     <= cfg_data[15:0];
                bsc_pkg::REG_OSR:       osr_reg       <= cfg_data[5:0];
            endcase
        end
    end

    // coefficient fields
    always_comb
    begin
        coef.c0    = temp_coef_reg[23:12];
        coef.c1    = temp_coef_reg[11:0];
        coef.c00   = p_offset_reg;
        coef.c10   = p_linear_reg;
        coef.c01   = t_cross_reg;
        coef.c11   = mixed_reg;
        coef.c20   = second_reg[31:16];
        coef.c21   = second_reg[15:0];
        coef.c30   = cubic_reg;
        coef.tcode = osr_reg[5:3];
        coef.pcode = osr_reg[2:0];
    end

    // pipeline advances unless the result register is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    bsc_scale_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (in_valid),
        .raw_temp     (raw_temp),
        .raw_pressure (raw_pressure),
        .tcode        (coef.tcode),
        .pcode        (coef.pcode),
        .out_vld      (div_vld),
        .t_val        (t_val),
        .p_val        (p_val)
    );

    bsc_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_vld      (div_vld),
        .t_val       (t_val),
        .p_val       (p_val),
        .coef        (coef),
        .out_vld     (out_valid),
        .temperature (temperature),
        .pressure_pa (pressure_pa)
    );

    // oversampling write lands
    osr_write_a: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == bsc_pkg::REG_OSR) |=> (osr_reg == $past(cfg_data[5:0])))
        else $error("oversampling register write lost");

    // other writes leave oversampling codes alone
    osr_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index != bsc_pkg::REG_OSR) |=> $stable(osr_reg))
        else $error("oversampling register disturbed");

    // temperature coefficient write lands
    tcoef_write_a: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == bsc_pkg::REG_TEMP_COEF)
            |=> (temp_coef_reg == $past(cfg_data[23:0])))
        else $error("temperature coefficient write lost");

endmodule

`default_nettype wire

FILE: tb/baro_sensor_compensation_core_tb.sv
// Testbench for baro_sensor_compensation_core: drives raw temperature/pressure words,
// predicts the compensated results in a scoreboard class and checks every output word.
// Depends on hdl/bsc_pkg.sv and hdl/baro_sensor_compensation_core.sv.
`timescale 1ns / 1ps

module baro_sensor_compensation_core_tb;

    localparam int FRAC = 24;
    localparam int PIPE_WAIT = 40;

    // Expected output word
    typedef struct {
        logic signed [16:0] temp;
        logic signed [23:0] pres;
    } comp_result_t;

    // Tracks calibration registers and predicts compensated outputs
    class comp_scoreboard;
        logic [31:0] regs [8];
        comp_result_t pending [$];
        int errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[bsc_pkg::REG_OSR] = 32'(bsc_pkg::OSR_RESET);
            errors = 0;
        endfunction

        function void write_reg(bsc_pkg::cfg_reg_t idx, logic [31:0] data);
            case (idx)
                bsc_pkg::REG_TEMP_COEF: regs[idx] = data & 32'hFF_FFFF;
                bsc_pkg::REG_P_OFFSET, bsc_pkg::REG_P_LINEAR: regs[idx] = data & 32'hF_FFFF;
                bsc_pkg::REG_SECOND: regs[idx] = data;
                bsc_pkg::REG_OSR: regs[idx] = data & 32'h3F;
                default: regs[idx] = data & 32'hFFFF;
            endcase
        endfunction

        function longint osr_factor(int code);
            case (code)
                0: return 524288;
                1: return 1572864;
                2: return 3670016;
                3: return 7864320;
                4: return 253952;
                5: return 516096;
                6: return 1040384;
                default: return 2088960;
            endcase
        endfunction

        // Raw reading to signed fixed point, truncated toward zero
        function longint scaled(logic signed [23:0] raw, int code);
            longint m;
            longint q;
            m = (raw < 0) ? -longint'(raw) : longint'(raw);
            q = (m << FRAC) / osr_factor(code);
            return (raw < 0) ? -q : q;
        endfunction

        function longint clamp_add(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -64'sh7FFF_FFFF_FFFF_FFFF;
            return s[63:0];
        endfunction

        // Fixed times fixed, truncated on the magnitude, clamped
        function longint fix_mul(longint a, longint b);
            logic [127:0] ua;
            logic [127:0] ub;
            logic [127:0] r;
            ua = (a < 0) ? 128'(-a) : 128'(a);
            ub = (b < 0) ? 128'(-b) : 128'(b);
            r = (ua * ub) >> FRAC;
            if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
            return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
        endfunction

        function void note_input(logic signed [23:0] rt, logic signed [23:0] rp);
            longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
            longint s, t, p, tv, a, b, sum;
            comp_result_t e;
            s   = 64'sd1 <<< FRAC;
            c0  = longint'($signed(regs[bsc_pkg::REG_TEMP_COEF][23:12]));
            c1  = longint'($signed(regs[bsc_pkg::REG_TEMP_COEF][11:0]));
            c00 = longint'($signed(regs[bsc_pkg::REG_P_OFFSET][19:0]));
            c10 = longint'($signed(regs[bsc_pkg::REG_P_LINEAR][19:0]));
            c01 = longint'($signed(regs[bsc_pkg::REG_T_CROSS][15:0]));
            c11 = longint'($signed(regs[bsc_pkg::REG_MIXED][15:0]));
            c20 = longint'($signed(regs[bsc_pkg::REG_SECOND][31:16]));
            c21 = longint'($signed(regs[bsc_pkg::REG_SECOND][15:0]));
            c30 = longint'($signed(regs[bsc_pkg::REG_CUBIC][15:0]));
            t = scaled(rt, int'(regs[bsc_pkg::REG_OSR][5:3]));
            p = scaled(rp, int'(regs[bsc_pkg::REG_OSR][2:0]));

            tv = (c0 * (64'sd1 <<< (FRAC - 1)) + c1 * t) / s;
            if (tv > bsc_pkg::TEMP_MAX) tv = bsc_pkg::TEMP_MAX;
            if (tv < bsc_pkg::TEMP_MIN) tv = bsc_pkg::TEMP_MIN;

            a = clamp_add(c20 * s, c30 * p);
            a = fix_mul(p, a);
            a = clamp_add(c10 * s, a);
            a = fix_mul(p, a);
            a = clamp_add(c00 * s, a);
            b = clamp_add(c11 * s, c21 * p);
            b = fix_mul(p, b);
            b = fix_mul(t, b);
            sum = clamp_add(clamp_add(a, c01 * t), b) / s;
            if (sum > bsc_pkg::PRES_MAX) sum = bsc_pkg::PRES_MAX;
            if (sum < bsc_pkg::PRES_MIN) sum = bsc_pkg::PRES_MIN;

            e.temp = tv[16:0];
            e.pres = sum[23:0];
            pending.push_back(e);
        endfunction

        function void check(logic signed [16:0] temp, logic signed [23:0] pres);
            comp_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word temp=%0d pres=%0d", $time, temp, pres);
                return;
            end
            e = pending.pop_front();
            if (temp !== e.temp)
            begin
                errors++;
                $display("%0t: temperature expected %0d actual %0d", $time, e.temp, temp);
            end
            if (pres !== e.pres)
            begin
                errors++;
                $display("%0t: pressure_pa expected %0d actual %0d", $time, e.pres, pres);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [23:0] raw_temp = '0;
    logic signed [23:0] raw_pressure = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [16:0] temperature;
    logic signed [23:0] pressure_pa;

    int idle_mode = 0;   // 0: sender 31/receiver 50, 1: swapped, 2: no idling
    comp_scoreboard sb = new();

    baro_sensor_compensation_core #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_temp(raw_temp), .raw_pressure(raw_pressure),
        .out_valid(out_valid), .out_stall(out_stall),
        .temperature(temperature), .pressure_pa(pressure_pa)
    );

    always #6 clk = ~clk;

    // Generous hard limit
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: random stall and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check(temperature, pressure_pa);
            case (idle_mode)
                0: out_stall <= ($urandom_range(99) < 50);
                1: out_stall <= ($urandom_range(99) < 31);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Send one word, with random gaps ahead of it
    task automatic send_word(logic signed [23:0] rt, logic signed [23:0] rp);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 31 : (idle_mode == 1) ? 50 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            raw_temp <= 24'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_temp <= rt;
        raw_pressure <= rp;
        do @(posedge clk); while (in_stall);
        sb.note_input(rt, rp);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    // Load all calibration registers; only called while the pipe is empty
    task automatic load_coefs(logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= bsc_pkg::CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(bsc_pkg::cfg_reg_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] vals [8];
        logic signed [23:0] edge_vals [6];
        edge_vals = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, -24'sd1, 24'sd1, 24'sh400000};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 9; ph++)
        begin
            idle_mode = (ph < 3) ? 0 : (ph < 6) ? 1 : 2;
            case (ph)
                0: ;  // reset defaults
                1: vals = '{32'h7FF7FF, 32'h7FFFF, 32'h7FFFF, 32'h7FFF, 32'h7FFF,
                            32'h7FFF7FFF, 32'h7FFF, 32'd36};
                2: vals = '{32'h800800, 32'h80000, 32'h80000, 32'h8000, 32'h8000,
                            32'h80008000, 32'h8000, 32'd63};
                3: vals = '{32'hFFFFFF, 32'hFFFFF, 32'hFFFFF, 32'hFFFF, 32'hFFFF,
                            32'hFFFFFFFF, 32'hFFFF, 32'd0};
                default: foreach (vals[i]) vals[i] = $urandom;
            endcase
            if (ph != 0)
            begin
                drain();
                load_coefs(vals);
            end
            // Field extremes against each corner setting
            if (ph < 4)
                foreach (edge_vals[i]) send_word(edge_vals[i], edge_vals[5 - i]);
            for (int n = 0; n < 90; n++)
            begin
                if ($urandom_range(3) == 0)
                    send_word(24'($urandom_range(2047)) - 24'sd1024,
                              24'($urandom_range(2047)) - 24'sd1024);
                else
                    send_word(24'($urandom), 24'($urandom));
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: baro_sensor_compensation_core.f
hdl/bsc_pkg.sv
hdl/bsc_delay.sv
hdl/bsc_scale_div.sv
hdl/bsc_fmul.sv
hdl/bsc_poly.sv
hdl/baro_sensor_compensation_core.sv
tb/baro_sensor_compensation_core_tb.sv
